@@ hdl/tfe_pkg.sv @@
// ----------------------------------------------------------------------------
// tfe_pkg
// shared types, codes and channel widening helpers for the texel expander
// ----------------------------------------------------------------------------
package tfe_pkg;

    localparam int TEXEL_W = 16;
    localparam int PIDX_W  = 8;
    localparam int ARGB_W  = 32;
    localparam int FMT_W   = 3;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 3;

    // source formats
    localparam logic [FMT_W-1:0] FMT_P8       = 3'd0;
    localparam logic [FMT_W-1:0] FMT_AP88     = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_ARGB1555 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_ARGB4444 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_ALPHA8   = 3'd5;

    // input functions
    localparam logic FUNC_PAL_WRITE = 1'b0;
    localparam logic FUNC_CONVERT   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_SOURCE_FORMAT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TARGET_FORMAT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_ALPHA8_EXPAND = 2'd2;

    localparam logic [7:0] CH_FULL = 8'hff;

    typedef struct packed {
        logic [FMT_W-1:0] source_format;
        logic             target_format;
        logic             alpha8_expand;
    } cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [PIDX_W-1:0] addr;
        logic [ARGB_W-1:0] wdata;
    } pal_req_t;

    typedef struct packed {
        logic               valid;
        logic [TEXEL_W-1:0] texel;
        logic               last;
        logic               hit;
    } st1_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [7:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] widen1(input logic v);
        return {8{v}};
    endfunction

endpackage

@@ hdl/texel_format_expander_top.sv @@
// ----------------------------------------------------------------------------
// texel_format_expander_top
// expands one texel per transaction into 8-bit red, green, blue and alpha
// ----------------------------------------------------------------------------
// Usage:
//   s_* is the input channel (valid/ready). func 0 writes palette_argb into
//   palette entry palette_index and gives no result; func 1 converts texel
//   per the source_format register and gives one result on m_*.
//   cfg_wr_en/cfg_addr/cfg_wdata write source_format (0), target_format (1)
//   and alpha8_expand (2); write them only while the block is idle.
// Pipeline and throughput:
//   an accepted texel is held in the read stage with its palette read,
//   then in the output register on m_*. One transaction is taken per
//   cycle unless m_* stalls; the palette memory takes the write and the
//   registered read on the accept edge, so a texel may follow its write.
// Reset:
//   aresetn empties both stages and loads the register defaults; the
//   palette contents are undefined until written, and there is no sweep.
// Stall:
//   while m_ready is low the result holds; one more texel is taken into the
//   read stage, then s_ready drops until the output drains.
// ----------------------------------------------------------------------------
module texel_format_expander_top
    import tfe_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [PIDX_W-1:0]   s_palette_index,
    input  logic [ARGB_W-1:0]   s_palette_argb,
    input  logic [TEXEL_W-1:0]  s_texel,
    input  logic                s_end_of_texture,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_red,
    output logic [7:0]          m_green,
    output logic [7:0]          m_blue,
    output logic [7:0]          m_alpha,
    output logic                m_has_alpha,
    output logic                m_last
);

    localparam logic [PIDX_W:0] PAL_LIMIT = (PIDX_W + 1)'(PALETTE_ENTRIES);

    cfg_t               cfg_reg;
    logic               st1_valid_reg, st1_valid_next;
    logic [TEXEL_W-1:0] st1_texel_reg;
    logic               st1_last_reg;
    logic               st1_hit_reg;
    logic               stage_ready;
    logic               s_fire;
    logic               conv_fire;
    logic [PIDX_W-1:0]  rd_idx;
    logic               wr_hit;
    logic               rd_hit;
    pal_req_t           pal_req;
    st1_t               st1;
    logic [ARGB_W-1:0]  pal_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_format <= FMT_RGB565;
            cfg_reg.target_format <= 1'b0;
            cfg_reg.alpha8_expand <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SOURCE_FORMAT: cfg_reg.source_format <= cfg_wdata;
                CFG_TARGET_FORMAT: cfg_reg.target_format <= cfg_wdata[0];
                CFG_ALPHA8_EXPAND: cfg_reg.alpha8_expand <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign s_ready   = !st1_valid_reg || stage_ready;
    assign s_fire    = s_valid && s_ready;
    assign conv_fire = s_fire && (s_func == FUNC_CONVERT);
    assign rd_idx    = s_texel[PIDX_W-1:0];
    assign wr_hit    = {1'b0, s_palette_index} < PAL_LIMIT;
    assign rd_hit    = {1'b0, rd_idx} < PAL_LIMIT;

    always_comb begin
        pal_req.wr_en = s_fire && (s_func == FUNC_PAL_WRITE) && wr_hit;
        pal_req.rd_en = conv_fire;
        pal_req.addr  = (s_func == FUNC_PAL_WRITE) ? s_palette_index : rd_idx;
        pal_req.wdata = s_palette_argb;
    end

    tfe_palette_ram #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .req     (pal_req),
        .rd_data (pal_data)
    );

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (conv_fire) begin
            st1_valid_next = 1'b1;
        end else if (stage_ready) begin
            st1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (conv_fire) begin
            st1_texel_reg <= s_texel;
            st1_last_reg  <= s_end_of_texture;
            st1_hit_reg   <= rd_hit;
        end
    end

    always_comb begin
        st1.valid = st1_valid_reg;
        st1.texel = st1_texel_reg;
        st1.last  = st1_last_reg;
        st1.hit   = st1_hit_reg;
    end

    tfe_expand u_expand (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .st1         (st1),
        .pal_data    (pal_data),
        .stage_ready (stage_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red       (m_red),
        .m_green     (m_green),
        .m_blue      (m_blue),
        .m_alpha     (m_alpha),
        .m_has_alpha (m_has_alpha),
        .m_last      (m_last)
    );

endmodule

@@ hdl/tfe_palette_ram.sv @@
// ----------------------------------------------------------------------------
// tfe_palette_ram
// argb palette memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tfe_palette_ram
    import tfe_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  logic              aclk,
    input  pal_req_t          req,
    output logic [ARGB_W-1:0] rd_data
);

    localparam int IDX_W = $clog2(ENTRIES);

    logic [ARGB_W-1:0] mem [ENTRIES];
    logic [IDX_W-1:0]  idx;

    assign idx = req.addr[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[idx] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[idx];
        end
    end

endmodule

@@ hdl/tfe_expand.sv @@
// ----------------------------------------------------------------------------
// tfe_expand
// format decode and channel widening into the output register
// ----------------------------------------------------------------------------
module tfe_expand
    import tfe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  st1_t              st1,
    input  logic [ARGB_W-1:0] pal_data,
    output logic              stage_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_red,
    output logic [7:0]        m_green,
    output logic [7:0]        m_blue,
    output logic [7:0]        m_alpha,
    output logic              m_has_alpha,
    output logic              m_last
);

    logic              m_valid_reg;
    logic              m_valid_next;
    logic [7:0]        red_reg, green_reg, blue_reg, alpha_reg;
    logic [7:0]        red_next, green_next, blue_next, alpha_next;
    logic              has_alpha_reg, has_alpha_next;
    logic              last_reg;
    logic [ARGB_W-1:0] entry;
    logic [TEXEL_W-1:0] tx;
    logic              load;

    assign stage_ready = !m_valid_reg || m_ready;
    assign load        = st1.valid && stage_ready;
    assign entry       = st1.hit ? pal_data : '0;
    assign tx          = st1.texel;

    always_comb begin
        red_next       = '0;
        green_next     = '0;
        blue_next      = '0;
        alpha_next     = '0;
        has_alpha_next = 1'b0;
        case (cfg.source_format)
            FMT_P8: begin
                red_next       = entry[23:16];
                green_next     = entry[15:8];
                blue_next      = entry[7:0];
                alpha_next     = CH_FULL;
                has_alpha_next = cfg.target_format;
            end
            FMT_AP88: begin
                red_next       = entry[23:16];
                green_next     = entry[15:8];
                blue_next      = entry[7:0];
                alpha_next     = tx[15:8];
                has_alpha_next = 1'b1;
            end
            FMT_RGB565: begin
                red_next       = widen5(tx[15:11]);
                green_next     = widen6(tx[10:5]);
                blue_next      = widen5(tx[4:0]);
                alpha_next     = CH_FULL;
                has_alpha_next = cfg.target_format;
            end
            FMT_ARGB1555: begin
                red_next       = widen5(tx[14:10]);
                green_next     = widen5(tx[9:5]);
                blue_next      = widen5(tx[4:0]);
                alpha_next     = widen1(tx[15]);
                has_alpha_next = 1'b1;
            end
            FMT_ARGB4444: begin
                red_next       = widen4(tx[11:8]);
                green_next     = widen4(tx[7:4]);
                blue_next      = widen4(tx[3:0]);
                alpha_next     = widen4(tx[15:12]);
                has_alpha_next = 1'b1;
            end
            FMT_ALPHA8: begin
                alpha_next     = tx[7:0];
                has_alpha_next = 1'b1;
                if (cfg.alpha8_expand) begin
                    red_next   = CH_FULL;
                    green_next = CH_FULL;
                    blue_next  = CH_FULL;
                end
            end
            default: begin
                red_next       = '0;
                green_next     = '0;
                blue_next      = '0;
                alpha_next     = '0;
                has_alpha_next = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            alpha_reg     <= alpha_next;
            has_alpha_reg <= has_alpha_next;
            last_reg      <= st1.last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red       = red_reg;
    assign m_green     = green_reg;
    assign m_blue      = blue_reg;
    assign m_alpha     = alpha_reg;
    assign m_has_alpha = has_alpha_reg;
    assign m_last      = last_reg;

endmodule
